FILE: hdl/sads_pkg.sv
// Shared types and operation codes for the two-stacks-in-one-array block.
`timescale 1ns / 1ps

package sads_pkg;

   localparam int FUNC_W = 3;
   localparam int WORD_W = 32;

   localparam logic [FUNC_W-1:0] FUNC_PUSH_LEFT  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_RIGHT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_LEFT   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_RIGHT  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PEEK_LEFT  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_PEEK_RIGHT = 3'd5;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load_peek;
   } cmd_type;

   typedef struct packed {
      logic read_pending;
   } status_type;

endpackage

FILE: hdl/sads_if.sv
// Request and response channel interfaces for the two-stacks-in-one-array block.
`timescale 1ns / 1ps

interface sads_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic signed [31:0] push_data;

   modport source (output valid, output func, output push_data, input ready);
   modport sink (input valid, input func, input push_data, output ready);
endinterface

interface sads_rsp_if;
   logic               valid;
   logic               ready;
   logic               ok;
   logic signed [31:0] peek_data;
   logic [8:0]         left_count;
   logic [8:0]         right_count;
   logic               both_empty;
   logic               is_full;

   modport source (output valid, output ok, output peek_data, output left_count,
                   output right_count, output both_empty, output is_full, input ready);
   modport sink (input valid, input ok, input peek_data, input left_count,
                 input right_count, input both_empty, input is_full, output ready);
endinterface

FILE: hdl/sads_ctrl.sv
// Controller state machine that sequences one request at a time through the datapath.
`timescale 1ns / 1ps

module sads_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  sads_pkg::status_type status,
   output sads_pkg::cmd_type    cmd
);
   import sads_pkg::*;

   typedef enum logic [1:0] {IDLE, EXEC, READ, RESP} state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            EXEC: begin
               if (status.read_pending) begin
                  state_ff <= READ;
               end else begin
                  state_ff     <= RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            READ: begin
               state_ff     <= RESP;
               rsp_valid_ff <= 1'b1;
            end
            RESP: begin
               if (rsp_ready) begin
                  state_ff     <= IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready     = req_ready_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign cmd.capture   = req_valid && req_ready_ff;
   assign cmd.execute   = (state_ff == EXEC);
   assign cmd.load_peek = (state_ff == READ);

endmodule

FILE: hdl/sads_datapath.sv
// Datapath with the shared word memory, the two stack pointers and the response registers.
`timescale 1ns / 1ps

module sads_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  sads_pkg::cmd_type    cmd,
   output sads_pkg::status_type status,
   input  logic [2:0]          req_func,
   input  logic signed [31:0]  req_push_data,
   output logic                rsp_ok,
   output logic signed [31:0]  rsp_peek_data,
   output logic [8:0]          rsp_left_count,
   output logic [8:0]          rsp_right_count,
   output logic                rsp_both_empty,
   output logic                rsp_is_full
);
   import sads_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   logic [WORD_W-1:0] mem [DEPTH];

   logic [FUNC_W-1:0] func_ff;
   logic [WORD_W-1:0] data_ff;
   logic [CW-1:0]     left_fill_ff, left_fill_in;
   logic [CW-1:0]     right_base_ff, right_base_in;
   logic              ok_ff, ok_in;
   logic [WORD_W-1:0] peek_data_ff;
   logic [WORD_W-1:0] rd_data_ff;

   logic              left_empty, right_empty, full;
   logic              we, re;
   logic [CW-1:0]     left_dec, right_dec, waddr_w, raddr_w;
   logic [CW+8:0]     left_ext, right_ext;
   logic [CW-1:0]     right_count;

   assign left_empty  = (left_fill_ff == '0);
   assign right_empty = (right_base_ff == DEPTH_C);
   assign full        = (left_fill_ff == right_base_ff);
   assign left_dec    = left_fill_ff - ONE_C;
   assign right_dec   = right_base_ff - ONE_C;

   always_comb begin
      left_fill_in  = left_fill_ff;
      right_base_in = right_base_ff;
      ok_in         = 1'b0;
      we            = 1'b0;
      re            = 1'b0;
      waddr_w       = left_fill_ff;
      raddr_w       = left_dec;
      case (func_ff)
         FUNC_PUSH_LEFT: begin
            if (!full) begin
               we           = 1'b1;
               left_fill_in = left_fill_ff + ONE_C;
               ok_in        = 1'b1;
            end
         end
         FUNC_PUSH_RIGHT: begin
            if (!full) begin
               we            = 1'b1;
               waddr_w       = right_dec;
               right_base_in = right_dec;
               ok_in         = 1'b1;
            end
         end
         FUNC_POP_LEFT: begin
            if (!left_empty) begin
               left_fill_in = left_dec;
               ok_in        = 1'b1;
            end
         end
         FUNC_POP_RIGHT: begin
            if (!right_empty) begin
               right_base_in = right_base_ff + ONE_C;
               ok_in         = 1'b1;
            end
         end
         FUNC_PEEK_LEFT: begin
            if (!left_empty) begin
               re    = 1'b1;
               ok_in = 1'b1;
            end
         end
         FUNC_PEEK_RIGHT: begin
            if (!right_empty) begin
               re      = 1'b1;
               raddr_w = right_base_ff;
               ok_in   = 1'b1;
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign status.read_pending = re;

   always_ff @(posedge clock) begin
      if (cmd.execute && we) begin
         mem[waddr_w[AW-1:0]] <= data_ff;
      end
      if (cmd.execute && re) begin
         rd_data_ff <= mem[raddr_w[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_fill_ff  <= '0;
         right_base_ff <= DEPTH_C;
      end else if (cmd.execute) begin
         left_fill_ff  <= left_fill_in;
         right_base_ff <= right_base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         data_ff <= req_push_data;
      end
      if (cmd.execute) begin
         ok_ff        <= ok_in;
         peek_data_ff <= '0;
      end else if (cmd.load_peek) begin
         peek_data_ff <= rd_data_ff;
      end
   end

   assign right_count = DEPTH_C - right_base_ff;
   assign left_ext    = {9'b0, left_fill_ff};
   assign right_ext   = {9'b0, right_count};

   assign rsp_ok          = ok_ff;
   assign rsp_peek_data   = peek_data_ff;
   assign rsp_left_count  = left_ext[8:0];
   assign rsp_right_count = right_ext[8:0];
   assign rsp_both_empty  = left_empty && right_empty;
   assign rsp_is_full     = full;

endmodule

FILE: hdl/shared_array_double_stack_top.sv
// Top level of the block that keeps two stacks in one shared word memory.
`timescale 1ns / 1ps

// Two stacks share a memory of DEPTH 32-bit words: the left stack grows up from
// entry 0 and the right stack grows down from the top. Each request pushes, pops
// or peeks one stack and returns one response with a success flag, the peeked
// word, both counts and the empty and full flags. Requests are handled one at a
// time: after a request is accepted the controller passes through its EXEC state
// to RESP, where the response is offered, and a successful peek also passes
// through READ on the way, because the memory read port is registered. A new
// request is accepted in the cycle after the response has been taken. Counts
// are reported modulo 512. Memory contents are not cleared at reset.
module shared_array_double_stack_top #(
   parameter int DEPTH = 256
) (
   input  logic      clock,
   input  logic      reset,
   sads_req_if.sink   req_channel,
   sads_rsp_if.source rsp_channel
);
   import sads_pkg::*;

   cmd_type    cmd;
   status_type status;

   sads_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sads_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_channel.func),
      .req_push_data   (req_channel.push_data),
      .rsp_ok          (rsp_channel.ok),
      .rsp_peek_data   (rsp_channel.peek_data),
      .rsp_left_count  (rsp_channel.left_count),
      .rsp_right_count (rsp_channel.right_count),
      .rsp_both_empty  (rsp_channel.both_empty),
      .rsp_is_full     (rsp_channel.is_full)
   );

endmodule
